>>> rtl/overlapping_frame_buffer_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros used by the overlapping frame buffer datapath.
// ----------------------------------------------------------------------------
`ifndef OVERLAPPING_FRAME_BUFFER_ASSERT_SVH
`define OVERLAPPING_FRAME_BUFFER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define OFB_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("overlapping_frame_buffer: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define OFB_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("overlapping_frame_buffer: next-cycle check failed");

`endif

>>> rtl/ofb_pkg.sv
// ----------------------------------------------------------------------------
// ofb_pkg
// Shared types and constants of the overlapping frame buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package ofb_pkg;

   // hop register width and reset divisor (reset hop is a quarter window)
   localparam int HOP_BITS    = 7;
   localparam int HOP_DIVISOR = 4;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOAD,
      ST_EMIT
   } ofb_state_type;

   // controller -> datapath
   typedef struct packed {
      logic accept;   // take the input beat: write ring, update count
      logic load;     // load the frame start address
      logic issue;    // read one frame sample into the output register
   } ofb_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic hit;      // accepted beat completes a hop
      logic last;     // next read is the final sample of the frame
      logic out_free; // output register can take a new beat this cycle
   } ofb_stat_type;

endpackage

`default_nettype wire

>>> rtl/ofb_ctrl.sv
// ----------------------------------------------------------------------------
// ofb_ctrl
// Sequencer: takes samples while idle, then walks the datapath through one
// frame readout per completed hop.
// ----------------------------------------------------------------------------
`default_nettype none

module ofb_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire ofb_pkg::ofb_stat_type stat,
   output ofb_pkg::ofb_cmd_type      cmd
);
   import ofb_pkg::*;

   ofb_state_type state_ff;
   ofb_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && stat.hit) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (stat.out_free && stat.last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_stall  = 1'b1;
      cmd.accept = 1'b0;
      cmd.load   = 1'b0;
      cmd.issue  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall  = 1'b0;
            cmd.accept = req_valid;
         end
         ST_LOAD: begin
            cmd.load = 1'b1;
         end
         ST_EMIT: begin
            cmd.issue = stat.out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

endmodule

`default_nettype wire

>>> rtl/ofb_datapath.sv
// ----------------------------------------------------------------------------
// ofb_datapath
// Sample ring, hop counter, frame address generation and output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "overlapping_frame_buffer_assert.svh"

module ofb_datapath #(
   parameter int WINDOW      = 64,
   parameter int RING_DEPTH  = 128,
   parameter int SAMPLE_BITS = 16
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire ofb_pkg::ofb_cmd_type         cmd,
   output ofb_pkg::ofb_stat_type             stat,
   input  wire logic                         csr_wr_en,
   input  wire logic [ofb_pkg::HOP_BITS-1:0] csr_wr_data,
   input  wire logic signed [SAMPLE_BITS-1:0] req_sample,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic signed [SAMPLE_BITS-1:0]     rsp_frame_sample,
   output logic                              rsp_frame_last
);
   import ofb_pkg::*;

   localparam int PW   = $clog2(RING_DEPTH);
   localparam int AW   = PW + 1;
   localparam int CW   = $clog2(WINDOW + 2);
   localparam int KW   = $clog2(WINDOW);
   localparam int CMPW = HOP_BITS + 1;

   localparam logic [HOP_BITS-1:0] HOP_RESET = HOP_BITS'(WINDOW / HOP_DIVISOR);
   localparam logic [HOP_BITS-1:0] HOP_MAX   = HOP_BITS'(WINDOW);
   localparam logic [HOP_BITS-1:0] HOP_ONE   = HOP_BITS'(1);
   localparam logic [CW-1:0]       CNT_MAX   = CW'(WINDOW);
   localparam logic [PW-1:0]       PTR_TOP   = PW'(RING_DEPTH - 1);
   localparam logic [AW-1:0]       RING_X    = AW'(RING_DEPTH);
   localparam logic [AW-1:0]       WIN_X     = AW'(WINDOW);
   localparam logic [KW-1:0]       K_LAST    = KW'(WINDOW - 1);

   logic signed [SAMPLE_BITS-1:0] ring_mem [RING_DEPTH];

   logic [HOP_BITS-1:0]    hop_ff;
   logic [PW-1:0]          wp_ff, wp_in;
   logic                   wrapped_ff;
   logic [CW-1:0]          cnt_ff, cnt_in;
   logic [PW-1:0]          rd_ptr_ff, rd_ptr_in;
   logic [KW-1:0]          k_ff;
   logic                   out_valid_ff;
   logic                   out_fill_ff;
   logic                   out_last_ff;
   logic signed [SAMPLE_BITS-1:0] out_data_ff;

   logic [HOP_BITS-1:0]    hop_eff;
   logic [CW-1:0]          cnt_inc;
   logic [CW-1:0]          cnt_rem;
   logic [AW-1:0]          end_x, start_x;

   // ---- hop bookkeeping ----
   always_comb begin
      hop_eff = hop_ff;
      if (hop_ff == '0) begin
         hop_eff = HOP_ONE;
      end else if (hop_ff > HOP_MAX) begin
         hop_eff = HOP_MAX;
      end
   end

   assign cnt_inc  = cnt_ff + 1'b1;
   assign stat.hit = CMPW'(cnt_inc) >= CMPW'(hop_eff);

   always_comb begin
      cnt_rem = cnt_inc - CW'(hop_eff);
      if (cnt_rem > CNT_MAX) begin
         cnt_rem = CNT_MAX;
      end
      cnt_in = stat.hit ? cnt_rem : cnt_inc;
   end

   assign wp_in = (wp_ff == PTR_TOP) ? '0 : wp_ff + 1'b1;

   // ---- frame addresses: end = wp - count, start = end - WINDOW (mod ring) ----
   always_comb begin
      if (AW'(wp_ff) >= AW'(cnt_ff)) begin
         end_x = AW'(wp_ff) - AW'(cnt_ff);
      end else begin
         end_x = AW'(wp_ff) + RING_X - AW'(cnt_ff);
      end
      if (end_x >= WIN_X) begin
         start_x = end_x - WIN_X;
      end else begin
         start_x = end_x + RING_X - WIN_X;
      end
   end

   always_comb begin
      rd_ptr_in = rd_ptr_ff;
      if (cmd.load) begin
         rd_ptr_in = start_x[PW-1:0];
      end else if (cmd.issue) begin
         rd_ptr_in = (rd_ptr_ff == PTR_TOP) ? '0 : rd_ptr_ff + 1'b1;
      end
   end

   assign stat.last     = (k_ff == K_LAST);
   assign stat.out_free = !out_valid_ff || !rsp_stall;

   // ---- control registers ----
   always_ff @(posedge clock) begin
      if (reset) begin
         hop_ff       <= HOP_RESET;
         wp_ff        <= '0;
         wrapped_ff   <= 1'b0;
         cnt_ff       <= '0;
         k_ff         <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            hop_ff <= csr_wr_data;
         end
         if (cmd.accept) begin
            wp_ff  <= wp_in;
            cnt_ff <= cnt_in;
            if (wp_ff == PTR_TOP) begin
               wrapped_ff <= 1'b1;
            end
         end
         if (cmd.issue) begin
            k_ff <= stat.last ? '0 : k_ff + 1'b1;
         end
         if (cmd.issue) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_ptr_ff <= rd_ptr_in;
   end

   // ---- sample ring ----
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         ring_mem[wp_ff] <= req_sample;
      end
   end

   // entries not yet written since reset read as zero
   always_ff @(posedge clock) begin
      if (cmd.issue) begin
         out_data_ff <= ring_mem[rd_ptr_ff];
         out_fill_ff <= wrapped_ff || (rd_ptr_ff < wp_ff);
         out_last_ff <= stat.last;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_frame_sample = out_fill_ff ? out_data_ff : '0;
   assign rsp_frame_last   = out_last_ff;

   `OFB_ASSERT_NEXT(a_cnt_bound, cmd.accept, cnt_ff <= CNT_MAX)
   `OFB_ASSERT_IMPL(a_no_overwrite, out_valid_ff && rsp_stall, !cmd.issue)
   `OFB_ASSERT_IMPL(a_frame_aligned, cmd.load, k_ff == '0)

endmodule

`default_nettype wire

>>> rtl/overlapping_frame_buffer.sv
// ----------------------------------------------------------------------------
// overlapping_frame_buffer
// Framing ring for short-time spectral analysis: emits the latest WINDOW
// samples, oldest first, every hop_size input samples.
// ----------------------------------------------------------------------------
// Usage:
//  - req_ channel: one sample per beat. Samples are taken only while no
//    frame is being read out; req_stall is high during readout.
//  - rsp_ channel: WINDOW beats per frame, rsp_frame_last on the final one.
//  - csr_: hop_size write (0 acts as 1, above WINDOW acts as WINDOW); write
//    only while the block is idle.
//  - A sample that completes a hop is followed by an address-load state and
//    then the readout state, one beat per cycle while the receiver keeps up;
//    each beat is read from the ring into the output register, which drives
//    rsp_valid. The sample ring has a single read port.
//  - A receiver stall holds the current beat in the output register and
//    pauses the readout; a new sample may be accepted while the final beat
//    still waits.
//  - Reset (synchronous): ring reads as all zeros, counters cleared, hop
//    set to WINDOW/4. No clearing pass; early frames start with zeros.
// ----------------------------------------------------------------------------
`default_nettype none

module overlapping_frame_buffer #(
   parameter int WINDOW      = 64,
   parameter int RING_DEPTH  = 128,
   parameter int SAMPLE_BITS = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_wr_en,
   input  wire logic [ofb_pkg::HOP_BITS-1:0]  csr_wr_data,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic signed [SAMPLE_BITS-1:0] req_sample,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic signed [SAMPLE_BITS-1:0]      rsp_frame_sample,
   output logic                               rsp_frame_last
);
   import ofb_pkg::*;

   ofb_cmd_type  cmd;
   ofb_stat_type stat;

   ofb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   ofb_datapath #(
      .WINDOW      (WINDOW),
      .RING_DEPTH  (RING_DEPTH),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_sample       (req_sample),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_frame_sample (rsp_frame_sample),
      .rsp_frame_last   (rsp_frame_last)
   );

endmodule

`default_nettype wire
